// ===== hw/rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, header layout and controller/datapath interface types
// for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 24;
    localparam int UNIT_BYTES   = 8;
    localparam int UNIT_SHIFT   = 3;
    localparam int REQ_W        = 16;
    localparam int OFF_W        = 16;

    localparam int HEAP_UNITS = HEAP_BYTES / UNIT_BYTES;
    localparam int HDR_UNITS  = HEADER_BYTES / UNIT_BYTES;
    localparam int ADDR_W     = $clog2(HEAP_UNITS);
    localparam int SPAN_W     = ADDR_W + 1;
    localparam int NEED_W     = REQ_W + 1 - UNIT_SHIFT;
    localparam int BYTE_W     = ADDR_W + UNIT_SHIFT + 1;
    localparam int ENTRY_W    = ADDR_W + 1;

    localparam logic [ENTRY_W-1:0] RESET_ENTRY =
        {1'b1, ADDR_W'(HEAP_UNITS - HDR_UNITS)};

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_RELEASED  = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    localparam logic [2:0] WR_NONE      = 3'd0;
    localparam logic [2:0] WR_SPLIT     = 3'd1;
    localparam logic [2:0] WR_TAKE_ALL  = 3'd2;
    localparam logic [2:0] WR_TAKE_NEED = 3'd3;
    localparam logic [2:0] WR_FREE      = 3'd4;
    localparam logic [2:0] WR_MERGE     = 3'd5;

    typedef struct packed {
        logic       load;
        logic       addr_zero;
        logic       addr_next;
        logic       cur_load;
        logic       cur_merge;
        logic [2:0] wr_op;
        logic       fin;
        logic [1:0] fin_code;
        logic       fin_grant;
    } cmd_t;

    typedef struct packed {
        logic in_kind;
        logic in_zero;
        logic in_null;
        logic rd_fit;
        logic rd_split;
        logic rd_end;
        logic rd_match;
        logic merge_ok;
    } sts_t;

endpackage

// ===== hw/rtl/ffba_dp.sv =====
// ----------------------------------------------------------------------------
// ffba_dp
// Datapath: header memory, walk pointer, current-block registers for the
// merge walk, and the result registers.
// ----------------------------------------------------------------------------
module ffba_dp
    import ffba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              kind,
    input  logic [REQ_W-1:0]  request_size,
    input  logic [OFF_W-1:0]  release_offset,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic [OFF_W-1:0]  payload_offset,
    output logic [1:0]        status
);

    logic [ENTRY_W-1:0] mem [HEAP_UNITS];

    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  raddr_reg;
    logic [ENTRY_W-1:0] rdata_reg;
    logic               init_done_reg;
    logic               init_done_next;
    logic [NEED_W-1:0]  need_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [ADDR_W-1:0]  cur_addr_reg;
    logic [ADDR_W-1:0]  cur_size_reg;
    logic               cur_free_reg;
    logic [OFF_W-1:0]   payload_reg;
    logic [1:0]         status_reg;

    logic [REQ_W:0]     req_round;
    logic [NEED_W-1:0]  need_in;
    logic [ENTRY_W-1:0] rd_entry;
    logic [ADDR_W-1:0]  rd_size;
    logic               rd_free;
    logic [SPAN_W-1:0]  rd_next;
    logic [BYTE_W-1:0]  rd_offset;
    logic [SPAN_W-1:0]  split_addr;
    logic [SPAN_W-1:0]  remainder;
    logic [SPAN_W-1:0]  merged;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    assign req_round = {1'b0, request_size} + (REQ_W + 1)'(UNIT_BYTES - 1);
    assign need_in   = req_round[REQ_W:UNIT_SHIFT];

    assign rd_entry = (raddr_reg == '0 && !init_done_reg) ? RESET_ENTRY : rdata_reg;
    assign rd_size  = rd_entry[ADDR_W-1:0];
    assign rd_free  = rd_entry[ADDR_W];

    assign rd_next    = {1'b0, raddr_reg} + SPAN_W'(HDR_UNITS) + {1'b0, rd_size};
    assign rd_offset  = {1'b0, raddr_reg, {UNIT_SHIFT{1'b0}}} + BYTE_W'(HEADER_BYTES);
    assign split_addr = {1'b0, raddr_reg} + SPAN_W'(HDR_UNITS) + need_reg;
    assign remainder  = {1'b0, rd_size} - need_reg - SPAN_W'(HDR_UNITS);
    assign merged     = {1'b0, cur_size_reg} + SPAN_W'(HDR_UNITS) + {1'b0, rd_size};

    assign sts.in_kind  = kind;
    assign sts.in_zero  = (request_size == '0);
    assign sts.in_null  = (release_offset == '0);
    assign sts.rd_fit   = rd_free && ({1'b0, rd_size} >= need_reg);
    assign sts.rd_split = {1'b0, rd_size} > (need_reg + SPAN_W'(HDR_UNITS + 1));
    assign sts.rd_end   = (rd_next >= SPAN_W'(HEAP_UNITS));
    assign sts.rd_match = (rd_offset == {{(BYTE_W - OFF_W){1'b0}}, off_reg});
    assign sts.merge_ok = cur_free_reg && rd_free;

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = addr_reg;
        wr_data = '0;
        case (cmd.wr_op)
            WR_SPLIT:
            begin
                wr_addr = split_addr[ADDR_W-1:0];
                wr_data = {1'b1, remainder[ADDR_W-1:0]};
            end
            WR_TAKE_ALL:  wr_data = {1'b0, rd_size};
            WR_TAKE_NEED: wr_data = {1'b0, need_reg[ADDR_W-1:0]};
            WR_FREE:      wr_data = {1'b1, rd_size};
            WR_MERGE:
            begin
                wr_addr = cur_addr_reg;
                wr_data = {1'b1, merged[ADDR_W-1:0]};
            end
            default:      wr_en = 1'b0;
        endcase
    end

    assign init_done_next = init_done_reg || (wr_en && wr_addr == '0);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[addr_reg];
        raddr_reg <= addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_done_reg <= 1'b0;
        end
        else
        begin
            init_done_reg <= init_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            need_reg <= need_in;
            off_reg  <= release_offset;
        end
        if (cmd.load || cmd.addr_zero)
        begin
            addr_reg <= '0;
        end
        else if (cmd.addr_next)
        begin
            addr_reg <= rd_next[ADDR_W-1:0];
        end
        if (cmd.cur_load)
        begin
            cur_addr_reg <= raddr_reg;
            cur_size_reg <= rd_size;
            cur_free_reg <= rd_free;
        end
        else if (cmd.cur_merge)
        begin
            cur_size_reg <= merged[ADDR_W-1:0];
        end
        if (cmd.fin)
        begin
            status_reg  <= cmd.fin_code;
            payload_reg <= cmd.fin_grant ? rd_offset[OFF_W-1:0] : '0;
        end
    end

    assign payload_offset = payload_reg;
    assign status         = status_reg;

endmodule

// ===== hw/rtl/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Controller: sequences the allocate walk, the release search and the
// merge walk, and raises the result strobe.
// ----------------------------------------------------------------------------
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy,
    output logic done
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_A_RD  = 4'd1;
    localparam logic [3:0] S_A_EV  = 4'd2;
    localparam logic [3:0] S_A_WR  = 4'd3;
    localparam logic [3:0] S_R_RD  = 4'd4;
    localparam logic [3:0] S_R_EV  = 4'd5;
    localparam logic [3:0] S_M_RD0 = 4'd6;
    localparam logic [3:0] S_M_LD  = 4'd7;
    localparam logic [3:0] S_M_RD  = 4'd8;
    localparam logic [3:0] S_M_EV  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       done_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.wr_op  = WR_NONE;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!sts.in_kind)
                    begin
                        if (sts.in_zero)
                        begin
                            cmd.fin      = 1'b1;
                            cmd.fin_code = ST_NO_FIT;
                        end
                        else
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_A_RD;
                        end
                    end
                    else if (sts.in_null)
                    begin
                        cmd.fin      = 1'b1;
                        cmd.fin_code = ST_IGNORED;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_R_RD;
                    end
                end
            end
            S_A_RD: state_next = S_A_EV;
            S_A_EV:
            begin
                if (sts.rd_fit)
                begin
                    if (sts.rd_split)
                    begin
                        cmd.wr_op  = WR_SPLIT;
                        state_next = S_A_WR;
                    end
                    else
                    begin
                        cmd.wr_op     = WR_TAKE_ALL;
                        cmd.fin       = 1'b1;
                        cmd.fin_code  = ST_ALLOCATED;
                        cmd.fin_grant = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else if (sts.rd_end)
                begin
                    cmd.fin      = 1'b1;
                    cmd.fin_code = ST_NO_FIT;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.addr_next = 1'b1;
                    state_next    = S_A_RD;
                end
            end
            S_A_WR:
            begin
                cmd.wr_op     = WR_TAKE_NEED;
                cmd.fin       = 1'b1;
                cmd.fin_code  = ST_ALLOCATED;
                cmd.fin_grant = 1'b1;
                state_next    = S_IDLE;
            end
            S_R_RD: state_next = S_R_EV;
            S_R_EV:
            begin
                if (sts.rd_match)
                begin
                    cmd.wr_op     = WR_FREE;
                    cmd.addr_zero = 1'b1;
                    state_next    = S_M_RD0;
                end
                else if (sts.rd_end)
                begin
                    cmd.fin      = 1'b1;
                    cmd.fin_code = ST_IGNORED;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.addr_next = 1'b1;
                    state_next    = S_R_RD;
                end
            end
            S_M_RD0: state_next = S_M_LD;
            S_M_LD:
            begin
                cmd.cur_load = 1'b1;
                if (sts.rd_end)
                begin
                    cmd.fin      = 1'b1;
                    cmd.fin_code = ST_RELEASED;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.addr_next = 1'b1;
                    state_next    = S_M_RD;
                end
            end
            S_M_RD: state_next = S_M_EV;
            S_M_EV:
            begin
                if (sts.merge_ok)
                begin
                    cmd.wr_op     = WR_MERGE;
                    cmd.cur_merge = 1'b1;
                end
                else
                begin
                    cmd.cur_load = 1'b1;
                end
                if (sts.rd_end)
                begin
                    cmd.fin      = 1'b1;
                    cmd.fin_code = ST_RELEASED;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.addr_next = 1'b1;
                    state_next    = S_M_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.fin;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ===== hw/rtl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a fixed heap with one header per block, splitting
// on allocate, merging free neighbors after each release of a found block.
//
//   Channel   Signals                                        Handshake
//   request   kind, request_size, release_offset             start & !busy
//   result    payload_offset, status                         done, one cycle
//
// Each block visited takes a memory read state, then an evaluation state.
// An allocate walks blocks until one fits or the heap ends, with a write
// state added when the block is split. A release walks blocks up to the
// target, then a merge walk over every block of the heap sets the worst case.
// A zero-size allocate or null release raises done in the cycle after start.
// After reset the heap is one free block; no clearing pass is needed.
// The receiver cannot stall: done is high for exactly one cycle per result.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             kind,
    input  logic [REQ_W-1:0] request_size,
    input  logic [OFF_W-1:0] release_offset,
    output logic             done,
    output logic [OFF_W-1:0] payload_offset,
    output logic [1:0]       status
);

    cmd_t cmd;
    sts_t sts;

    ffba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ffba_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .kind           (kind),
        .request_size   (request_size),
        .release_offset (release_offset),
        .cmd            (cmd),
        .sts            (sts),
        .payload_offset (payload_offset),
        .status         (status)
    );

`ifndef SYNTHESIS
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("Accepted transaction made no progress.");

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("Result strobe without a transaction.");

    a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_ALLOCATED) |-> (payload_offset != '0))
        else $error("Allocation reported with a null offset.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_ALLOCATED) |-> (payload_offset == '0))
        else $error("Non-allocation result carries an offset.");
`endif

endmodule

// ===== dv/ffba_heap_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_heap_checker
// Watches the request and result channels of the first-fit block allocator.
// It keeps its own map of the heap and works out the reply to each accepted
// transaction, then compares every reply from the block with the oldest one
// still owed.
// ----------------------------------------------------------------------------
module ffba_heap_checker
    import ffba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             kind,
    input  logic [REQ_W-1:0] request_size,
    input  logic [OFF_W-1:0] release_offset,
    input  logic             done,
    input  logic [OFF_W-1:0] payload_offset,
    input  logic [1:0]       status,
    output int unsigned      mismatches,
    output int unsigned      replies_owed
);

    localparam int MAX_BLOCKS = HEAP_BYTES / (HEADER_BYTES + UNIT_BYTES) + 1;
    localparam logic [BYTE_W-1:0] ALIGN_MASK = BYTE_W'(UNIT_BYTES - 1);
    localparam logic [BYTE_W-1:0] HDR_BYTES  = BYTE_W'(HEADER_BYTES);
    localparam logic [BYTE_W-1:0] SPLIT_SLACK = BYTE_W'(HEADER_BYTES + UNIT_BYTES);

    typedef struct packed {
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] payload_bytes;
        logic              is_free;
    } span_entry_t;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [1:0]       code;
    } reply_t;

    span_entry_t heap_map[$];
    reply_t      expected_replies[$];
    reply_t      oldest_reply;
    int unsigned fail_total;

    function automatic void clear_heap();
        span_entry_t whole;
        whole.base          = '0;
        whole.payload_bytes = BYTE_W'(HEAP_BYTES - HEADER_BYTES);
        whole.is_free       = 1'b1;
        heap_map.delete();
        heap_map.push_back(whole);
    endfunction

    function automatic reply_t allocate_block(input logic [REQ_W-1:0] bytes);
        logic [BYTE_W-1:0] need;
        span_entry_t       blk;
        span_entry_t       spare;
        reply_t            r;
        int                i;
        r.offset = '0;
        r.code   = ST_NO_FIT;
        if (bytes == '0)
        begin
            return r;
        end
        need = (BYTE_W'(bytes) + ALIGN_MASK) & ~ALIGN_MASK;
        for (i = 0; i < heap_map.size(); i++)
        begin
            blk = heap_map[i];
            if (blk.is_free && blk.payload_bytes >= need)
            begin
                if (blk.payload_bytes > need + SPLIT_SLACK && heap_map.size() < MAX_BLOCKS)
                begin
                    spare.base          = blk.base + HDR_BYTES + need;
                    spare.payload_bytes = blk.payload_bytes - need - HDR_BYTES;
                    spare.is_free       = 1'b1;
                    heap_map.insert(i + 1, spare);
                    blk.payload_bytes = need;
                end
                blk.is_free = 1'b0;
                heap_map[i] = blk;
                r.offset = OFF_W'(blk.base + HDR_BYTES);
                r.code   = ST_ALLOCATED;
                return r;
            end
        end
        return r;
    endfunction

    function automatic reply_t release_block(input logic [OFF_W-1:0] target);
        span_entry_t blk;
        span_entry_t nxt;
        reply_t      r;
        int          i;
        int          hit;
        r.offset = '0;
        r.code   = ST_IGNORED;
        if (target == '0)
        begin
            return r;
        end
        hit = -1;
        for (i = 0; i < heap_map.size() && hit < 0; i++)
        begin
            if (heap_map[i].base + HDR_BYTES == BYTE_W'(target))
            begin
                hit = i;
            end
        end
        if (hit < 0)
        begin
            return r;
        end
        blk = heap_map[hit];
        blk.is_free = 1'b1;
        heap_map[hit] = blk;
        i = 0;
        while (i + 1 < heap_map.size())
        begin
            blk = heap_map[i];
            nxt = heap_map[i + 1];
            if (blk.is_free && nxt.is_free)
            begin
                blk.payload_bytes = blk.payload_bytes + HDR_BYTES + nxt.payload_bytes;
                heap_map[i] = blk;
                heap_map.delete(i + 1);
            end
            else
            begin
                i++;
            end
        end
        r.code = ST_RELEASED;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_heap();
            expected_replies.delete();
            fail_total = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("Result with no transaction outstanding: payload_offset %0d, status %0d",
                           payload_offset, status);
                    fail_total++;
                end
                else
                begin
                    oldest_reply = expected_replies.pop_front();
                    if (payload_offset !== oldest_reply.offset)
                    begin
                        $error("payload_offset mismatch: expected %0d, actual %0d",
                               oldest_reply.offset, payload_offset);
                        fail_total++;
                    end
                    if (status !== oldest_reply.code)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest_reply.code, status);
                        fail_total++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_replies.push_back(kind ? release_block(release_offset)
                                                : allocate_block(request_size));
            end
        end
        mismatches   <= fail_total;
        replies_owed <= expected_replies.size();
    end

endmodule

// ===== dv/tb_first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Drives allocate and release transactions into the first-fit block allocator:
// a directed pass over the boundary cases, then random traffic whose releases
// mostly target granted blocks, mixed with stale, null and stray releases.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam logic        KIND_ALLOC   = 1'b0;
    localparam logic        KIND_RELEASE = 1'b1;
    localparam int unsigned RANDOM_ITEMS = 1600;
    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned LIVE_CAP     = 40;
    localparam int unsigned HISTORY_CAP  = 16;

    logic             clk;
    logic             rst_n          = 1'b0;
    logic             start          = 1'b0;
    logic             kind           = 1'b0;
    logic [REQ_W-1:0] request_size   = '0;
    logic [OFF_W-1:0] release_offset = '0;
    logic             busy;
    logic             done;
    logic [OFF_W-1:0] payload_offset;
    logic [1:0]       status;

    int unsigned      mismatches;
    int unsigned      replies_owed;
    int unsigned      cycle_count = 0;

    logic [OFF_W-1:0] live_blocks[$];
    logic [OFF_W-1:0] freed_blocks[$];

    first_fit_block_allocator dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .request_size   (request_size),
        .release_offset (release_offset),
        .done           (done),
        .payload_offset (payload_offset),
        .status         (status)
    );

    ffba_heap_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .request_size   (request_size),
        .release_offset (release_offset),
        .done           (done),
        .payload_offset (payload_offset),
        .status         (status),
        .mismatches     (mismatches),
        .replies_owed   (replies_owed)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done && status == ST_ALLOCATED)
        begin
            live_blocks.push_back(payload_offset);
        end
    end

    task automatic send(input logic k, input logic [REQ_W-1:0] bytes,
                        input logic [OFF_W-1:0] target);
        kind           <= k;
        request_size   <= bytes;
        release_offset <= target;
        start          <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_alloc(input logic [REQ_W-1:0] bytes);
        send(KIND_ALLOC, bytes, OFF_W'($urandom));
    endtask

    task automatic send_release(input logic [OFF_W-1:0] target);
        send(KIND_RELEASE, REQ_W'($urandom), target);
    endtask

    task automatic hold_off(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        hold_off(1);
        while (replies_owed != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic release_live_block();
        int unsigned      idx;
        logic [OFF_W-1:0] target;
        idx    = $urandom_range(0, live_blocks.size() - 1);
        target = live_blocks[idx];
        live_blocks.delete(idx);
        freed_blocks.push_back(target);
        if (freed_blocks.size() > HISTORY_CAP)
        begin
            void'(freed_blocks.pop_front());
        end
        send_release(target);
    endtask

    function automatic logic [REQ_W-1:0] pick_size();
        int unsigned band;
        band = $urandom_range(0, 99);
        if (band < 60)
        begin
            return REQ_W'($urandom_range(1, 256));
        end
        else if (band < 85)
        begin
            return REQ_W'($urandom_range(257, 4096));
        end
        else if (band < 97)
        begin
            return REQ_W'($urandom_range(4097, 16384));
        end
        return REQ_W'($urandom_range(16385, 65535));
    endfunction

    initial
    begin
        int unsigned sent;
        int unsigned choice;
        logic        paused;

        repeat (8)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        send_alloc(16'd0);
        send_release(16'd0);
        send_alloc(16'hFFFF);
        send_alloc(REQ_W'(HEAP_BYTES - HEADER_BYTES));
        send_alloc(16'd1);
        send_release(16'd24);
        send_release(16'd24);
        send_alloc(REQ_W'(HEAP_BYTES - 2 * HEADER_BYTES - 8));
        send_release(16'd24);
        send_alloc(REQ_W'(HEAP_BYTES - 2 * HEADER_BYTES - 16));
        send_alloc(16'd16);
        send_alloc(16'd1);
        send_release(16'hFFFF);
        send_release(16'd65520);
        send_release(16'd24);
        send_alloc(16'd1);
        send_alloc(16'd9);
        send_alloc(16'd100);
        send_release(16'd56);
        send_alloc(16'd8);
        send_release(16'hAAAA);
        send_release(16'h5555);
        send_release(16'd96);
        send_release(16'd56);
        send_release(16'd24);

        drain_results();
        live_blocks.delete();

        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if ((sent < 700 || sent > 1000) && $urandom_range(0, 99) < 8)
            begin
                hold_off($urandom_range(1, 6));
            end
            if (sent == 400 && !paused)
            begin
                drain_results();
                paused = 1'b1;
            end
            choice = $urandom_range(0, 99);
            if (live_blocks.size() >= LIVE_CAP
                || (choice >= 50 && choice < 85 && live_blocks.size() != 0))
            begin
                release_live_block();
                sent++;
            end
            else if (choice >= 85 && choice < 90 && freed_blocks.size() != 0)
            begin
                send_release(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
                sent++;
            end
            else if (choice >= 90 && choice < 95)
            begin
                send_release(($urandom_range(0, 3) == 0) ? '0 : OFF_W'($urandom));
            end
            else if (choice >= 95)
            begin
                send_alloc(($urandom_range(0, 1) == 0) ? '0
                           : REQ_W'($urandom_range(HEAP_BYTES - HEADER_BYTES - 64, 65535)));
                sent++;
            end
            else
            begin
                send_alloc(pick_size());
                sent++;
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (mismatches == 0 && replies_owed == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
